FILE: design/bce_pkg.sv
// Package for the battery charge estimator: payload types, register indexes and breakpoint tables.
package bce_pkg;

  localparam int ADC_BITS   = 12;
  localparam int GAIN_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int SEG_W      = 4;
  localparam int NUM_SEGS   = 11;
  localparam int RISE_W     = 5;
  localparam int RECIP_W    = 22;
  localparam int RECIP_SHIFT = 28;
  localparam int QUOT_W     = 9;

  localparam logic [MV_W-1:0]  MV_MAX  = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [GAIN_W-1:0] FRONT_GAIN_RESET = 20'd329936;
  localparam logic [GAIN_W-1:0] REAR_GAIN_RESET  = 20'd329597;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_GAIN  = 2'd1;

  typedef struct packed {
    logic                channel;
    logic [ADC_BITS-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [PCT_W-1:0] charge_percent;
    logic [MV_W-1:0]  voltage_mv;
  } result_t;

  // Segment k spans from breakpoint k (its base) up to breakpoint k-1.
  // Segment zero means the voltage is at or below the lowest breakpoint.
  localparam logic [MV_W-1:0] SEG_BASE_MV [NUM_SEGS] = '{
    16'd0, 16'd10050, 16'd9975, 16'd9900, 16'd9825, 16'd9750,
    16'd9675, 16'd9600, 16'd9375, 16'd9000, 16'd7500
  };

  localparam logic [PCT_W-1:0] SEG_BASE_PCT [NUM_SEGS] = '{
    7'd0, 7'd99, 7'd90, 7'd70, 7'd40, 7'd30, 7'd20, 7'd17, 7'd14, 7'd9, 7'd0
  };

  localparam logic [RISE_W-1:0] SEG_RISE [NUM_SEGS] = '{
    5'd0, 5'd1, 5'd9, 5'd20, 5'd30, 5'd10, 5'd10, 5'd3, 5'd3, 5'd5, 5'd9
  };

  // Rounded-up reciprocals of each segment's width in millivolts, scaled by
  // two to the RECIP_SHIFT. Exact quotients for any 16-bit numerator.
  localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
    22'd0, 22'd1789570, 22'd3579140, 22'd3579140, 22'd3579140, 22'd3579140,
    22'd3579140, 22'd3579140, 22'd1193047, 22'd715828, 22'd178957
  };

endpackage

FILE: design/battery_charge_estimator.sv
// Top level of the battery charge estimator: gain registers and a seven-stage pipeline.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------------
//   item      | start / busy               | bce_pkg::item_t (channel, sample)
//   result    | result_valid (strobe)      | bce_pkg::result_t (percent, mV)
//   config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One sample is taken every clock cycle while rst is low; its result strobe follows it
// through the valid shift register beside the data stages of the two multiplies and the
// table search. The pipeline never stalls, since the receiver takes every result strobe.
// Reset clears the valid bits and loads the gain registers; busy is high only
// while rst is held.
module battery_charge_estimator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bce_pkg::item_t                      item,
  output logic                                result_valid,
  output bce_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bce_pkg::GAIN_W-1:0]          cfg_data
);

  localparam int PROD_W = bce_pkg::ADC_BITS + bce_pkg::GAIN_W;
  localparam int NUM_W  = bce_pkg::MV_W;
  localparam int QPROD_W = NUM_W + bce_pkg::RECIP_W;
  localparam int SUM_W  = bce_pkg::QUOT_W + 1;

  logic [bce_pkg::GAIN_W-1:0] front_gain;
  logic [bce_pkg::GAIN_W-1:0] rear_gain;

  logic [6:0] v;

  logic [bce_pkg::ADC_BITS-1:0] s1_sample;
  logic [bce_pkg::GAIN_W-1:0]   s1_gain;
  logic [PROD_W-1:0]            s2_prod;
  logic [bce_pkg::MV_W-1:0]     s3_mv;
  logic [bce_pkg::MV_W-1:0]     s4_mv;
  logic [bce_pkg::SEG_W-1:0]    s4_seg;
  logic [bce_pkg::MV_W-1:0]     s5_mv;
  logic [bce_pkg::SEG_W-1:0]    s5_seg;
  logic [NUM_W-1:0]             s5_num;
  logic [bce_pkg::MV_W-1:0]     s6_mv;
  logic [bce_pkg::SEG_W-1:0]    s6_seg;
  logic [bce_pkg::QUOT_W-1:0]   s6_quot;
  bce_pkg::result_t             s7_result;

  logic                       accept;
  logic [PROD_W-1:0]          mv_wide;
  logic [bce_pkg::MV_W-1:0]   mv_next;
  logic [bce_pkg::SEG_W-1:0]  seg_next;
  logic [bce_pkg::MV_W-1:0]   diff;
  logic [NUM_W+bce_pkg::RISE_W-1:0] num_wide;
  logic [QPROD_W-1:0]         qprod;
  logic [SUM_W-1:0]           pct_sum;
  logic [bce_pkg::PCT_W-1:0]  pct_next;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_gain <= bce_pkg::FRONT_GAIN_RESET;
      rear_gain  <= bce_pkg::REAR_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bce_pkg::REG_FRONT_GAIN: front_gain <= cfg_data;
        bce_pkg::REG_REAR_GAIN:  rear_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], accept};
    end
  end

  always_comb begin
    mv_wide = s2_prod >> 16;
    if (mv_wide > PROD_W'(bce_pkg::MV_MAX)) begin
      mv_next = bce_pkg::MV_MAX;
    end else begin
      mv_next = mv_wide[bce_pkg::MV_W-1:0];
    end
  end

  // Highest segment whose base the voltage exceeds, searched with parallel
  // compares; the lowest index wins.
  always_comb begin
    seg_next = '0;
    for (int k = bce_pkg::NUM_SEGS - 1; k >= 1; k--) begin
      if (s3_mv > bce_pkg::SEG_BASE_MV[k]) begin
        seg_next = bce_pkg::SEG_W'(k);
      end
    end
  end

  always_comb begin
    diff     = s4_mv - bce_pkg::SEG_BASE_MV[s4_seg];
    num_wide = diff * bce_pkg::SEG_RISE[s4_seg];
  end

  assign qprod = s5_num * bce_pkg::SEG_RECIP[s5_seg];

  always_comb begin
    pct_sum = SUM_W'(bce_pkg::SEG_BASE_PCT[s6_seg]) + SUM_W'(s6_quot);
    if (pct_sum > SUM_W'(bce_pkg::PCT_MAX)) begin
      pct_next = bce_pkg::PCT_MAX;
    end else begin
      pct_next = pct_sum[bce_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_sample <= item.adc_sample;
    s1_gain   <= item.channel ? rear_gain : front_gain;
    s2_prod   <= s1_sample * s1_gain;
    s3_mv     <= mv_next;
    s4_mv     <= s3_mv;
    s4_seg    <= seg_next;
    s5_mv     <= s4_mv;
    s5_seg    <= s4_seg;
    // Within a segment the numerator stays below 2^16, so the top bits are zero.
    s5_num    <= num_wide[NUM_W-1:0];
    s6_mv     <= s5_mv;
    s6_seg    <= s5_seg;
    s6_quot   <= qprod[bce_pkg::RECIP_SHIFT +: bce_pkg::QUOT_W];
    s7_result.charge_percent <= pct_next;
    s7_result.voltage_mv     <= s6_mv;
  end

  assign result_valid = v[6];
  assign result       = s7_result;

endmodule

FILE: design/bce_checker.sv
// Port-level checker for the battery charge estimator, bound to the top level.
module bce_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  result_valid,
  input bce_pkg::result_t      result
);

  localparam int LATENCY = 7;

  // Every accepted beat yields exactly one result after the pipeline latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY result_valid)
    else $error("accepted sample produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching sample");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.charge_percent <= bce_pkg::PCT_MAX))
    else $error("charge percent above 100");

  // At or below the lowest breakpoint the estimate must be empty.
  a_low_voltage: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.voltage_mv <= 16'd7500) |-> (result.charge_percent == '0))
    else $error("nonzero charge at low voltage");

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
